// ----- src/apdu_purse_card_engine_unit_macros.svh -----
// Assertion macros used by the purse engine checker.
`ifndef APDU_PURSE_CARD_ENGINE_UNIT_MACROS_SVH
`define APDU_PURSE_CARD_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication on the rising clock edge, quiet while in reset.
`define APCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on the rising clock edge, quiet while in reset.
`define APCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/apce_pkg.sv -----
// Types, constants and helper functions of the purse card engine.
package apce_pkg;

  localparam int RECORD_BYTES_DEF  = 32;
  localparam int VERSION_BYTES_DEF = 4;
  localparam int RECORD_COUNT      = 3;

  localparam logic [7:0] CLA_ADMIN = 8'h81;
  localparam logic [7:0] CLA_PURSE = 8'h82;

  localparam logic [7:0] INS_VERSION = 8'h00;
  localparam logic [7:0] INS_BALANCE = 8'h01;
  localparam logic [7:0] INS_DEBIT   = 8'h03;
  localparam logic [7:0] INS_REC_MAX = 8'h06;

  localparam logic [7:0] SW1_OK        = 8'h90;
  localparam logic [7:0] SW1_REFUSED   = 8'h61;
  localparam logic [7:0] SW1_WRONG_LEN = 8'h6C;
  localparam logic [7:0] SW1_BAD_INS   = 8'h6D;
  localparam logic [7:0] SW1_BAD_CLA   = 8'h6E;
  localparam logic [7:0] SW2_NONE      = 8'h00;

  localparam logic [7:0] AMOUNT_LEN = 8'd2;
  localparam logic [2:0] HDR_LAST   = 3'd4;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_RECORD,
    PH_AMOUNT
  } phase_e;

  typedef enum logic [3:0] {
    CMD_VERSION,
    CMD_WRITE,
    CMD_WRITE_EMPTY,
    CMD_READ,
    CMD_BALANCE,
    CMD_AMOUNT,
    CMD_BAD_LEN,
    CMD_BAD_INS,
    CMD_BAD_CLA
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_ECHO,
    S_VER,
    S_RDATA,
    S_BAL_HI,
    S_BAL_LO,
    S_SW1,
    S_SW2
  } state_e;

  typedef enum logic [2:0] {
    SEL_ECHO,
    SEL_VER,
    SEL_MEM,
    SEL_BAL_HI,
    SEL_BAL_LO,
    SEL_SW1,
    SEL_SW2
  } sel_e;

  typedef struct packed {
    logic take;
    logic start;
    logic emit;
    sel_e sel;
    logic last;
    logic adv;
    logic rd_first;
    logic rd_next;
  } ctl_t;

  typedef struct packed {
    cmd_e kind;
    logic hdr_done;
    logic data_done;
    logic seq_last;
    logic len_zero;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] version_byte(logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h31;
      4'd1:    b = 8'h2E;
      4'd2:    b = 8'h30;
      4'd3:    b = 8'h30;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- src/apce_if.sv -----
// Valid/ready channel interfaces for received and sent bytes.
interface apce_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface apce_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       run_end;

  modport source (output valid, output tx_byte, output run_end, input ready);
  modport sink   (input valid, input tx_byte, input run_end, output ready);
endinterface

// ----- src/apce_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module apce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/apce_ctrl.sv -----
// Command sequencer: takes bytes, decodes headers and paces the response bytes.
module apce_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rx_valid_i,
  output logic          rx_ready_o,
  input  apce_pkg::sts_t sts_i,
  output apce_pkg::ctl_t ctl_o
);
  import apce_pkg::*;

  state_e state_q, state_d;
  cmd_e   kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= CMD_BAD_CLA;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    ctl_o   = '0;
    ctl_o.sel = SEL_ECHO;
    case (state_q)
      S_IDLE: begin
        if (rx_valid_i) begin
          ctl_o.take = 1'b1;
          if (sts_i.hdr_done) begin
            state_d = S_DEC;
          end else if (sts_i.data_done) begin
            state_d = S_SW1;
          end
        end
      end
      S_DEC: begin
        ctl_o.start = 1'b1;
        kind_d = sts_i.kind;
        case (sts_i.kind)
          CMD_BAD_LEN, CMD_BAD_INS, CMD_BAD_CLA: state_d = S_SW1;
          default:                               state_d = S_ECHO;
        endcase
      end
      S_ECHO: begin
        if (sts_i.out_free) begin
          ctl_o.emit     = 1'b1;
          ctl_o.sel      = SEL_ECHO;
          ctl_o.last     = (kind_q == CMD_WRITE) || (kind_q == CMD_AMOUNT);
          ctl_o.rd_first = (kind_q == CMD_READ);
          case (kind_q)
            CMD_VERSION:           state_d = S_VER;
            CMD_READ:              state_d = sts_i.len_zero ? S_SW1 : S_RDATA;
            CMD_BALANCE:           state_d = S_BAL_HI;
            CMD_WRITE, CMD_AMOUNT: state_d = S_IDLE;
            default:               state_d = S_SW1;
          endcase
        end
      end
      S_VER: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          ctl_o.sel  = SEL_VER;
          ctl_o.adv  = 1'b1;
          if (sts_i.seq_last) begin
            state_d = S_SW1;
          end
        end
      end
      S_RDATA: begin
        if (sts_i.out_free) begin
          ctl_o.emit    = 1'b1;
          ctl_o.sel     = SEL_MEM;
          ctl_o.adv     = 1'b1;
          ctl_o.rd_next = 1'b1;
          if (sts_i.seq_last) begin
            state_d = S_SW1;
          end
        end
      end
      S_BAL_HI: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          ctl_o.sel  = SEL_BAL_HI;
          state_d    = S_BAL_LO;
        end
      end
      S_BAL_LO: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          ctl_o.sel  = SEL_BAL_LO;
          state_d    = S_SW1;
        end
      end
      S_SW1: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          ctl_o.sel  = SEL_SW1;
          state_d    = S_SW2;
        end
      end
      S_SW2: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          ctl_o.sel  = SEL_SW2;
          ctl_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign rx_ready_o = (state_q == S_IDLE);

endmodule

// ----- src/apce_dp.sv -----
// Datapath: header fields, record store, purse balance and output register.
module apce_dp #(
  parameter int RECORD_BYTES  = apce_pkg::RECORD_BYTES_DEF,
  parameter int VERSION_BYTES = apce_pkg::VERSION_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  apce_pkg::ctl_t ctl_i,
  output apce_pkg::sts_t sts_o,
  input  logic [7:0]     rx_byte_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [7:0]     tx_byte_o,
  output logic           run_end_o
);
  import apce_pkg::*;

  localparam int DEPTH   = RECORD_COUNT * RECORD_BYTES;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int LEN_W   = $clog2(RECORD_BYTES + 1);
  localparam int SEQ_MAX = (RECORD_BYTES > 16) ? RECORD_BYTES : 16;
  localparam int SEQ_W   = $clog2(SEQ_MAX + 1);

  logic [7:0]       cls_q, ins_q, len_q, amth_q, sw1_q, sw2_q;
  logic [2:0]       hcnt_q;
  phase_e           phase_q;
  logic [SEQ_W-1:0] idx_q;
  logic [LEN_W-1:0] reclen_q [RECORD_COUNT];
  logic [15:0]      bal_q;
  logic             out_valid_q, end_q;
  logic [7:0]       tx_q;

  logic [2:0]        ins_m1;
  logic [1:0]        rec;
  logic [LEN_W-1:0]  rec_len;
  cmd_e              kind;
  logic [7:0]        sw1_dec, sw2_dec;
  logic              seq_last, out_free;
  logic [SEQ_W-1:0]  rd_idx;
  logic [ADDR_W-1:0] base, waddr, raddr;
  logic              re;
  logic [7:0]        rdata;
  logic              we;
  logic [15:0]       amount;
  logic [16:0]       sum;
  logic              refused;
  logic [7:0]        tx_sel;

  assign ins_m1  = ins_q[2:0] - 3'd1;
  assign rec     = ins_m1[2:1];
  assign rec_len = reclen_q[rec];

  always_comb begin
    kind    = CMD_BAD_CLA;
    sw2_dec = SW2_NONE;
    if (cls_q == CLA_ADMIN) begin
      if (ins_q == INS_VERSION) begin
        if (len_q != 8'(VERSION_BYTES)) begin
          kind    = CMD_BAD_LEN;
          sw2_dec = 8'(VERSION_BYTES);
        end else begin
          kind = CMD_VERSION;
        end
      end else if (ins_q <= INS_REC_MAX) begin
        if (ins_q[0]) begin
          if (len_q > 8'(RECORD_BYTES)) begin
            kind    = CMD_BAD_LEN;
            sw2_dec = 8'(RECORD_BYTES);
          end else if (len_q == 8'd0) begin
            kind = CMD_WRITE_EMPTY;
          end else begin
            kind = CMD_WRITE;
          end
        end else if (len_q != 8'(rec_len)) begin
          kind    = CMD_BAD_LEN;
          sw2_dec = 8'(rec_len);
        end else begin
          kind = CMD_READ;
        end
      end else begin
        kind = CMD_BAD_INS;
      end
    end else if (cls_q == CLA_PURSE) begin
      if ((ins_q >= INS_BALANCE) && (ins_q <= INS_DEBIT)) begin
        if (len_q != AMOUNT_LEN) begin
          kind    = CMD_BAD_LEN;
          sw2_dec = AMOUNT_LEN;
        end else if (ins_q == INS_BALANCE) begin
          kind = CMD_BALANCE;
        end else begin
          kind = CMD_AMOUNT;
        end
      end else begin
        kind = CMD_BAD_INS;
      end
    end
  end

  always_comb begin
    case (kind)
      CMD_BAD_LEN: sw1_dec = SW1_WRONG_LEN;
      CMD_BAD_INS: sw1_dec = SW1_BAD_INS;
      CMD_BAD_CLA: sw1_dec = SW1_BAD_CLA;
      default:     sw1_dec = SW1_OK;
    endcase
  end

  assign seq_last = (8'(idx_q) == (len_q - 8'd1));
  assign out_free = !out_valid_q || out_ready_i;

  assign amount  = {amth_q, rx_byte_i};
  assign sum     = {1'b0, bal_q} + {1'b0, amount};
  assign refused = (ins_q == INS_DEBIT) ? (bal_q < amount) : sum[16];

  assign base   = ADDR_W'(rec) * ADDR_W'(RECORD_BYTES);
  assign rd_idx = idx_q + SEQ_W'(ctl_i.rd_next);
  assign raddr  = base + ADDR_W'(rd_idx);
  assign waddr  = base + ADDR_W'(idx_q);
  assign re     = ctl_i.rd_first || (ctl_i.rd_next && !seq_last);
  assign we     = ctl_i.take && (phase_q == PH_RECORD);

  apce_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_apce_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (rx_byte_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      hcnt_q   <= '0;
      idx_q    <= '0;
      bal_q    <= '0;
      reclen_q <= '{default: '0};
    end else if (ctl_i.take) begin
      case (phase_q)
        PH_RECORD: begin
          idx_q <= idx_q + SEQ_W'(1);
          if (seq_last) begin
            reclen_q[rec] <= LEN_W'(len_q);
            phase_q       <= PH_HEADER;
          end
        end
        PH_AMOUNT: begin
          if (idx_q == '0) begin
            idx_q <= SEQ_W'(1);
          end else begin
            phase_q <= PH_HEADER;
            if (!refused) begin
              bal_q <= (ins_q == INS_DEBIT) ? (bal_q - amount) : sum[15:0];
            end
          end
        end
        default: begin
          hcnt_q <= (hcnt_q == HDR_LAST) ? 3'd0 : hcnt_q + 3'd1;
        end
      endcase
    end else if (ctl_i.start) begin
      idx_q <= '0;
      case (kind)
        CMD_WRITE:       phase_q <= PH_RECORD;
        CMD_AMOUNT:      phase_q <= PH_AMOUNT;
        CMD_WRITE_EMPTY: reclen_q[rec] <= '0;
        default:         phase_q <= PH_HEADER;
      endcase
    end else if (ctl_i.adv) begin
      idx_q <= idx_q + SEQ_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      case (phase_q)
        PH_AMOUNT: begin
          if (idx_q == '0) begin
            amth_q <= rx_byte_i;
          end else begin
            sw1_q <= refused ? SW1_REFUSED : SW1_OK;
            sw2_q <= SW2_NONE;
          end
        end
        PH_RECORD: begin
          sw1_q <= SW1_OK;
          sw2_q <= SW2_NONE;
        end
        default: begin
          case (hcnt_q)
            3'd0:     cls_q <= rx_byte_i;
            3'd1:     ins_q <= rx_byte_i;
            HDR_LAST: len_q <= rx_byte_i;
            default:  ;
          endcase
        end
      endcase
    end else if (ctl_i.start) begin
      sw1_q <= sw1_dec;
      sw2_q <= sw2_dec;
    end
  end

  always_comb begin
    case (ctl_i.sel)
      SEL_ECHO:   tx_sel = ins_q;
      SEL_VER:    tx_sel = version_byte(idx_q[3:0]);
      SEL_MEM:    tx_sel = rdata;
      SEL_BAL_HI: tx_sel = bal_q[15:8];
      SEL_BAL_LO: tx_sel = bal_q[7:0];
      SEL_SW1:    tx_sel = sw1_q;
      SEL_SW2:    tx_sel = sw2_q;
      default:    tx_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      tx_q  <= tx_sel;
      end_q <= ctl_i.last;
    end
  end

  assign sts_o.kind      = kind;
  assign sts_o.hdr_done  = (phase_q == PH_HEADER) && (hcnt_q == HDR_LAST);
  assign sts_o.data_done = ((phase_q == PH_RECORD) && seq_last) ||
                           ((phase_q == PH_AMOUNT) && (idx_q != '0));
  assign sts_o.seq_last  = seq_last;
  assign sts_o.len_zero  = (len_q == 8'd0);
  assign sts_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign tx_byte_o   = tx_q;
  assign run_end_o   = end_q;

endmodule

// ----- src/apdu_purse_card_engine_unit.sv -----
// Top level of the T=0 purse card engine: sequencer plus datapath.
//
//  channel | dir | payload           | handshake
//  rx_i    | in  | rx_byte[7:0]      | valid/ready
//  tx_o    | out | tx_byte[7:0], run_end | valid/ready
//
// A byte that causes no response leaves rx_i ready. The fifth header byte holds
// rx_i off while the response (up to RECORD_BYTES + 3 bytes) goes out: a decode
// state, then one byte per cycle into the single output register while tx_o
// does not stall. The last data byte of a write, credit or debit holds rx_i off
// while the two status bytes go out. A stall on tx_o holds the sequencer;
// rx_i is taken again while the last byte still waits in the output register.
// Reset is asynchronous; the record store is not cleared.
module apdu_purse_card_engine_unit #(
  parameter int RECORD_BYTES  = apce_pkg::RECORD_BYTES_DEF,
  parameter int VERSION_BYTES = apce_pkg::VERSION_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  apce_rx_if.sink   rx_i,
  apce_tx_if.source tx_o
);
  import apce_pkg::*;

  ctl_t ctl;
  sts_t sts;

  apce_ctrl u_apce_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .rx_ready_o (rx_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  apce_dp #(
    .RECORD_BYTES  (RECORD_BYTES),
    .VERSION_BYTES (VERSION_BYTES)
  ) u_apce_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .rx_byte_i   (rx_i.rx_byte),
    .out_ready_i (tx_o.ready),
    .out_valid_o (tx_o.valid),
    .tx_byte_o   (tx_o.tx_byte),
    .run_end_o   (tx_o.run_end)
  );

endmodule

// ----- src/apce_checker.sv -----
// Port-level checker for the purse card engine and its bind.
`include "apdu_purse_card_engine_unit_macros.svh"

module apce_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_valid_i,
  input logic       rx_ready_i,
  input logic       tx_valid_i,
  input logic       tx_ready_i,
  input logic [7:0] tx_byte_i,
  input logic       run_end_i
);

  `APCE_ASSERT_NXT(tx_hold_a, clk_i, rst_ni, tx_valid_i && !tx_ready_i, tx_valid_i, "tx item dropped while stalled")
  `APCE_ASSERT_NXT(tx_stable_a, clk_i, rst_ni, tx_valid_i && !tx_ready_i, $stable(tx_byte_i) && $stable(run_end_i), "tx payload changed while stalled")
  `APCE_ASSERT_IMP(rx_ready_fall_a, clk_i, rst_ni, $fell(rx_ready_i), $past(rx_valid_i && rx_ready_i), "rx ready dropped without an accepted item")
  `APCE_ASSERT_IMP(tx_rise_busy_a, clk_i, rst_ni, $rose(tx_valid_i), $past(!rx_ready_i), "response byte started while idle")

endmodule

bind apdu_purse_card_engine_unit apce_checker u_apce_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .rx_valid_i (rx_i.valid),
  .rx_ready_i (rx_i.ready),
  .tx_valid_i (tx_o.valid),
  .tx_ready_i (tx_o.ready),
  .tx_byte_i  (tx_o.tx_byte),
  .run_end_i  (tx_o.run_end)
);

// ----- sim/tb_apdu_purse_card_engine_unit.sv -----
// Testbench of the purse card engine: command stimulus, response prediction, checking.
module tb_apdu_purse_card_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import apce_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_ITEMS = 240;
  localparam logic [7:0] INS_CREDIT = 8'h02;
  localparam logic [7:0] CLA_OTHER = 8'h00;
  localparam logic [7:0] VERSION_TEXT [4] = '{8'h31, 8'h2E, 8'h30, 8'h30};

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       run_end;
  } tx_beat_t;

  logic clk_i;
  logic rst_ni;

  apce_rx_if rx_bus ();
  apce_tx_if tx_bus ();

  apdu_purse_card_engine_unit uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_bus),
    .tx_o  (tx_bus)
  );

  // card state mirror
  phase_e     card_phase = PH_HEADER;
  int         card_hdr_cnt = 0;
  logic [7:0] card_cla = '0;
  logic [7:0] card_ins = '0;
  logic [7:0] card_len = '0;
  int         card_idx = 0;
  logic [7:0] card_store [RECORD_COUNT * RECORD_BYTES_DEF];
  logic [7:0] card_rec_len [RECORD_COUNT] = '{default: '0};
  logic [15:0] card_balance = '0;
  logic [7:0] card_amount_hi = '0;

  tx_beat_t   response_q [$];
  logic [7:0] reply_bytes [$];

  int  error_count = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  int  recv_wait = 0;
  int  recv_hold = 0;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add_status(input logic [7:0] sw1, input logic [7:0] sw2);
    reply_bytes.push_back(sw1);
    reply_bytes.push_back(sw2);
  endtask

  task automatic predict_reply(input logic [7:0] b);
    int rec;
    logic [15:0] amount;
    logic [16:0] sum;
    tx_beat_t beat;
    reply_bytes.delete();
    case (card_phase)
      PH_RECORD: begin
        rec = ((int'(card_ins) - 1) >> 1) % RECORD_COUNT;
        if (card_idx < RECORD_BYTES_DEF) card_store[rec * RECORD_BYTES_DEF + card_idx] = b;
        card_idx++;
        if (card_idx >= card_len) begin
          card_rec_len[rec] = card_len;
          card_phase = PH_HEADER;
          add_status(SW1_OK, SW2_NONE);
        end
      end
      PH_AMOUNT: begin
        if (card_idx == 0) begin
          card_amount_hi = b;
          card_idx = 1;
        end else begin
          amount = {card_amount_hi, b};
          card_phase = PH_HEADER;
          if (card_ins == INS_CREDIT) begin
            sum = {1'b0, card_balance} + {1'b0, amount};
            if (sum[16]) begin
              add_status(SW1_REFUSED, SW2_NONE);
            end else begin
              card_balance = sum[15:0];
              add_status(SW1_OK, SW2_NONE);
            end
          end else if (card_balance < amount) begin
            add_status(SW1_REFUSED, SW2_NONE);
          end else begin
            card_balance = card_balance - amount;
            add_status(SW1_OK, SW2_NONE);
          end
        end
      end
      default: begin
        case (card_hdr_cnt)
          0: card_cla = b;
          1: card_ins = b;
          4: card_len = b;
          default: ;
        endcase
        if (card_hdr_cnt >= int'(HDR_LAST)) begin
          card_hdr_cnt = 0;
          card_phase = PH_HEADER;
          if (card_cla == CLA_ADMIN) begin
            if (card_ins == INS_VERSION) begin
              if (card_len != VERSION_BYTES_DEF) begin
                add_status(SW1_WRONG_LEN, 8'(VERSION_BYTES_DEF));
              end else begin
                reply_bytes.push_back(card_ins);
                for (int i = 0; i < VERSION_BYTES_DEF; i++)
                  reply_bytes.push_back(i < 4 ? VERSION_TEXT[i] : 8'h00);
                add_status(SW1_OK, SW2_NONE);
              end
            end else if (card_ins <= INS_REC_MAX) begin
              rec = (int'(card_ins) - 1) >> 1;
              if (card_ins[0]) begin
                if (card_len > RECORD_BYTES_DEF) begin
                  add_status(SW1_WRONG_LEN, 8'(RECORD_BYTES_DEF));
                end else begin
                  reply_bytes.push_back(card_ins);
                  if (card_len == 8'd0) begin
                    card_rec_len[rec] = 8'd0;
                    add_status(SW1_OK, SW2_NONE);
                  end else begin
                    card_idx = 0;
                    card_phase = PH_RECORD;
                  end
                end
              end else if (card_len != card_rec_len[rec]) begin
                add_status(SW1_WRONG_LEN, card_rec_len[rec]);
              end else begin
                reply_bytes.push_back(card_ins);
                for (int i = 0; i < card_len; i++)
                  reply_bytes.push_back(card_store[rec * RECORD_BYTES_DEF + i]);
                add_status(SW1_OK, SW2_NONE);
              end
            end else begin
              add_status(SW1_BAD_INS, SW2_NONE);
            end
          end else if (card_cla == CLA_PURSE) begin
            if (card_ins >= INS_BALANCE && card_ins <= INS_DEBIT) begin
              if (card_len != AMOUNT_LEN) begin
                add_status(SW1_WRONG_LEN, AMOUNT_LEN);
              end else begin
                reply_bytes.push_back(card_ins);
                if (card_ins == INS_BALANCE) begin
                  reply_bytes.push_back(card_balance[15:8]);
                  reply_bytes.push_back(card_balance[7:0]);
                  add_status(SW1_OK, SW2_NONE);
                end else begin
                  card_idx = 0;
                  card_phase = PH_AMOUNT;
                end
              end
            end else begin
              add_status(SW1_BAD_INS, SW2_NONE);
            end
          end else begin
            add_status(SW1_BAD_CLA, SW2_NONE);
          end
        end else begin
          card_hdr_cnt++;
        end
      end
    endcase
    foreach (reply_bytes[i]) begin
      beat.tx_byte = reply_bytes[i];
      beat.run_end = (i == reply_bytes.size() - 1);
      response_q.push_back(beat);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = send_idle ? $urandom_range(0, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      rx_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    do @(posedge clk_i); while (!rx_bus.ready);
    predict_reply(b);
    items_sent++;
  endtask

  // header, then whatever data the card now waits for
  task automatic run_command(input logic [7:0] cla, input logic [7:0] ins,
                             input logic [7:0] len, input logic [15:0] amount);
    send_byte(cla);
    send_byte(ins);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(8'($urandom_range(0, 255)));
    send_byte(len);
    while (card_phase == PH_RECORD) send_byte(8'($urandom_range(0, 255)));
    if (card_phase == PH_AMOUNT) begin
      send_byte(amount[15:8]);
      send_byte(amount[7:0]);
    end
  endtask

  task automatic wait_replies_done;
    @(negedge clk_i);
    rx_bus.valid <= 1'b0;
    while (response_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (recv_hold > 0) begin
      recv_hold--;
      tx_bus.ready <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait--;
      tx_bus.ready <= 1'b0;
    end else begin
      tx_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    tx_beat_t want;
    if (rst_ni && tx_bus.valid && tx_bus.ready) begin
      recv_wait = recv_idle ? $urandom_range(0, 6) : 0;
      if (response_q.size() == 0) begin
        $error("unexpected item: tx_byte %02h run_end %0b", tx_bus.tx_byte, tx_bus.run_end);
        error_count++;
      end else begin
        want = response_q.pop_front();
        if (tx_bus.tx_byte !== want.tx_byte) begin
          $error("tx_byte expected %02h actual %02h", want.tx_byte, tx_bus.tx_byte);
          error_count++;
        end
        if (tx_bus.run_end !== want.run_end) begin
          $error("run_end expected %0b actual %0b", want.run_end, tx_bus.run_end);
          error_count++;
        end
      end
    end
  end

  task automatic test_version;
    run_command(CLA_ADMIN, INS_VERSION, 8'(VERSION_BYTES_DEF), '0);
    run_command(CLA_ADMIN, INS_VERSION, 8'h00, '0);
    run_command(CLA_ADMIN, INS_VERSION, 8'hFF, '0);
  endtask

  task automatic test_records;
    run_command(CLA_ADMIN, 8'h01, 8'h00, '0);
    run_command(CLA_ADMIN, 8'h02, 8'h00, '0);
    run_command(CLA_ADMIN, 8'h05, 8'(RECORD_BYTES_DEF), '0);
    run_command(CLA_ADMIN, INS_REC_MAX, 8'(RECORD_BYTES_DEF), '0);
    run_command(CLA_ADMIN, 8'h04, 8'h05, '0);
    run_command(CLA_ADMIN, 8'h03, 8'(RECORD_BYTES_DEF + 1), '0);
    run_command(CLA_ADMIN, 8'h03, 8'h01, '0);
    run_command(CLA_ADMIN, 8'h04, 8'h01, '0);
  endtask

  task automatic test_purse;
    run_command(CLA_PURSE, INS_BALANCE, AMOUNT_LEN, '0);
    run_command(CLA_PURSE, INS_CREDIT, AMOUNT_LEN, 16'hFFFF);
    run_command(CLA_PURSE, INS_CREDIT, AMOUNT_LEN, 16'h0001);
    run_command(CLA_PURSE, INS_BALANCE, AMOUNT_LEN, '0);
    run_command(CLA_PURSE, INS_DEBIT, AMOUNT_LEN, 16'hFFFF);
    run_command(CLA_PURSE, INS_DEBIT, AMOUNT_LEN, 16'h0001);
    run_command(CLA_PURSE, INS_BALANCE, 8'h03, '0);
  endtask

  task automatic test_errors;
    run_command(CLA_ADMIN, INS_REC_MAX + 8'd1, 8'h00, '0);
    run_command(CLA_ADMIN, 8'hFF, 8'hFF, '0);
    run_command(CLA_PURSE, 8'h00, AMOUNT_LEN, '0);
    run_command(CLA_PURSE, INS_DEBIT + 8'd1, AMOUNT_LEN, '0);
    run_command(CLA_OTHER, INS_BALANCE, AMOUNT_LEN, '0);
    run_command(8'hFF, 8'h00, 8'h00, '0);
  endtask

  task automatic test_backpressure;
    send_idle = 1'b0;
    recv_hold = 400;
    run_command(CLA_ADMIN, 8'h01, 8'(RECORD_BYTES_DEF), '0);
    run_command(CLA_ADMIN, 8'h02, 8'(RECORD_BYTES_DEF), '0);
    run_command(CLA_ADMIN, 8'h02, 8'(RECORD_BYTES_DEF), '0);
    run_command(CLA_PURSE, INS_BALANCE, AMOUNT_LEN, '0);
    wait_replies_done();
    send_idle = 1'b1;
  endtask

  task automatic test_random_commands;
    int first;
    int pick;
    int rec;
    int noise_len;
    logic [7:0] len;
    logic [15:0] amount;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) begin
        send_idle = ($urandom_range(0, 2) != 0);
        recv_idle = ($urandom_range(0, 2) != 0);
      end
      pick = $urandom_range(0, 99);
      rec = $urandom_range(0, RECORD_COUNT - 1);
      amount = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                          : 16'($urandom_range(0, 300));
      if (pick < 8) begin
        len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'(VERSION_BYTES_DEF);
        run_command(CLA_ADMIN, INS_VERSION, len, '0);
      end else if (pick < 28) begin
        len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, RECORD_BYTES_DEF));
        run_command(CLA_ADMIN, 8'(2 * rec + 1), len, '0);
      end else if (pick < 44) begin
        len = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : card_rec_len[rec];
        run_command(CLA_ADMIN, 8'(2 * rec + 2), len, '0);
      end else if (pick < 52) begin
        run_command(CLA_PURSE, INS_BALANCE, AMOUNT_LEN, '0);
      end else if (pick < 66) begin
        len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : AMOUNT_LEN;
        run_command(CLA_PURSE, INS_CREDIT, len, amount);
      end else if (pick < 80) begin
        len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : AMOUNT_LEN;
        run_command(CLA_PURSE, INS_DEBIT, len, amount);
      end else if (pick < 85) begin
        run_command($urandom_range(0, 1) ? CLA_ADMIN : CLA_PURSE,
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), amount);
      end else if (pick < 89) begin
        run_command(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), amount);
      end else if (pick < 96) begin
        noise_len = $urandom_range(1, 7);
        repeat (noise_len) send_byte(8'($urandom_range(0, 255)));
        while (!(card_phase == PH_HEADER && card_hdr_cnt == 0))
          send_byte(8'($urandom_range(0, 255)));
      end else begin
        wait_replies_done();
      end
    end
  endtask

  initial begin
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = '0;
    tx_bus.ready   = 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_version();
    test_records();
    test_purse();
    test_errors();
    wait_replies_done();
    test_backpressure();
    test_random_commands();
    wait_replies_done();

    if (error_count == 0 && response_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
